@@ hdl/shp3_pkg.sv @@
// Package for the 3x3 sharpening filter: result word type, register indexes, kernel function.
`default_nettype none
package shp3_pkg;

   // configuration register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // reset values of the configuration registers
   localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

   // largest frame height the counters support
   localparam logic [12:0] MAX_HEIGHT = 13'd4096;

   // one result word as it waits in the output queue
   typedef struct packed {
      logic [11:0] row;
      logic [10:0] col;
      logic [23:0] pix;
      logic        last;
   } result_type;

   // 5*centre minus the up, down, left and right neighbors, per 8-bit channel, clamped to 0..255
   function automatic logic [23:0] sharpen(input logic [23:0] cen, input logic [23:0] up,
                                           input logic [23:0] dn, input logic [23:0] lf,
                                           input logic [23:0] rt);
      logic [23:0] res;
      logic [11:0] v;
      logic [11:0] cc;
      res = 24'd0;
      for (int k = 0; k < 3; k++) begin
         cc = {4'b0, cen[8*k +: 8]};
         // modular 12-bit sum; the true value lies in -1020..1275
         v = (cc << 2) + cc - {4'b0, up[8*k +: 8]} - {4'b0, dn[8*k +: 8]}
             - {4'b0, lf[8*k +: 8]} - {4'b0, rt[8*k +: 8]};
         if (v[11]) begin
            res[8*k +: 8] = 8'd0;
         end else if (v > 12'd255) begin
            res[8*k +: 8] = 8'd255;
         end else begin
            res[8*k +: 8] = v[7:0];
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ hdl/shp3_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none
module shp3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

@@ hdl/sharpen_3x3_rgb.sv @@
// 3x3 sharpening filter for raster-order BGR pixels, with line buffer RAM and output queue.
//
// Usage: pixels enter on the req_ channel in raster order, one word per pixel, and results
// leave on the rsp_ channel, each tagged with its row and column. Interior pixels get
// 5*centre minus their edge neighbors per channel, clamped; border pixels are copied.
// An input word gives zero to four results; rsp_run_last marks the last one of them.
// Row 0 gives none, a row end gives two, the last row gives up to four per word.
// Frame size comes from the csr_ port (index 0 width, index 1 height), written while idle.
// A result passes through the RAM stage and then the output queue before it reaches rsp_.
// Throughput: one word per cycle while the queue keeps up; the line RAM read (both lines in
// one word, read at the column on accept, written back as the word leaves the RAM stage)
// is pipelined, so the rate is set by the single output port: words with one or more
// results hold req_ready low until the queue is empty or is handing over its last result.
// Reset clears the row/column counters, RAM stage and queue and restores 640x480; the line
// RAM and window need no clearing since no entry's data is used before it has been written.
// When the receiver stalls, results wait in a four-entry queue and req_ready drops while
// the one-word RAM stage holds a word with results that the queue cannot yet take.
`default_nettype none
module sharpen_3x3_rgb
   import shp3_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input pixels
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_blue,
   input  wire logic [7:0]  req_in_green,
   input  wire logic [7:0]  req_in_red,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_out_row,
   output logic [10:0]      rsp_out_col,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_red,
   output logic             rsp_run_last,
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_wdata
);

   localparam int          AW   = $clog2(MAX_WIDTH);
   localparam logic [13:0] MAXW = 14'(MAX_WIDTH);

   // configuration registers
   logic [11:0] fwidth_ff;
   logic [12:0] fheight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwidth_ff  <= FRAME_WIDTH_RST;
         fheight_ff <= FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fwidth_ff  <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT: fheight_ff <= csr_wdata;
            default:          fwidth_ff  <= fwidth_ff;
         endcase
      end
   end

   // effective frame size, clamped
   logic [13:0] w_eff;
   logic [12:0] h_eff;

   always_comb begin
      w_eff = {2'b0, fwidth_ff};
      if (w_eff < 14'd3) begin
         w_eff = 14'd3;
      end else if (w_eff > MAXW) begin
         w_eff = MAXW;
      end
      h_eff = fheight_ff;
      if (h_eff < 13'd3) begin
         h_eff = 13'd3;
      end else if (h_eff > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end
   end

   // handshake and pipeline control
   logic        accept;
   logic        b_valid_ff;
   logic        b_move;
   logic        c_can_load;
   logic        c_load;
   logic        take;
   logic [3:0]  b_en_ff;
   logic [2:0]  count_ff;

   assign take       = rsp_valid && rsp_ready;
   assign c_can_load = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_ready);
   assign b_move     = b_valid_ff && (b_en_ff == 4'd0 || c_can_load);
   assign c_load     = b_move && (b_en_ff != 4'd0);
   assign req_ready  = !b_valid_ff || b_move;
   assign accept     = req_valid && req_ready;

   // position counters and per-word flags
   logic [11:0] row_ff, row_in;
   logic [10:0] col_ff, col_in;
   logic        row_end, last_row, interior;
   logic [3:0]  en_in;

   always_comb begin
      row_end  = ({3'b0, col_ff} + 14'd1) >= w_eff;
      last_row = ({1'b0, row_ff} + 13'd1) >= h_eff;
      interior = (row_ff >= 12'd2) && (col_ff >= 11'd2)
                 && (({3'b0, col_ff} + 14'd1) <= w_eff);
      en_in[0] = (row_ff != 12'd0) && (col_ff != 11'd0);
      en_in[1] = (row_ff != 12'd0) && row_end;
      en_in[2] = last_row && (col_ff != 11'd0);
      en_in[3] = last_row && row_end;
      if (row_end) begin
         col_in = 11'd0;
         row_in = last_row ? 12'd0 : row_ff + 12'd1;
      end else begin
         col_in = col_ff + 11'd1;
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 12'd0;
         col_ff <= 11'd0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // RAM stage: word waits here while the line RAM read completes
   logic [11:0]   b_row_ff;
   logic [10:0]   b_col_ff;
   logic [23:0]   b_pix_ff;
   logic          b_interior_ff;
   logic [AW-1:0] b_addr_ff;
   logic [AW-1:0] raddr;

   assign raddr = AW'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (accept) begin
         b_valid_ff <= 1'b1;
      end else if (b_move) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_row_ff      <= row_ff;
         b_col_ff      <= col_ff;
         b_pix_ff      <= {req_in_red, req_in_green, req_in_blue};
         b_interior_ff <= interior;
         b_en_ff       <= en_in;
         b_addr_ff     <= raddr;
      end
   end

   // line RAM: upper half the older line, lower half the newer line
   logic [47:0] ram_q;
   logic [23:0] top, mid;

   shp3_ram #(
      .WIDTH (48),
      .DEPTH (MAX_WIDTH)
   ) u_lines (
      .clock (clock),
      .we    (b_move),
      .waddr (b_addr_ff),
      .wdata ({mid, b_pix_ff}),
      .re    (accept),
      .raddr (raddr),
      .rdata (ram_q)
   );

   assign top = ram_q[47:24];
   assign mid = ram_q[23:0];

   // window of the previous two columns (only the taps in use are kept)
   logic [23:0] win_left_ff;   // middle row, column c-2
   logic [23:0] win_top_ff;    // top row, column c-1
   logic [23:0] win_mid_ff;    // middle row, column c-1
   logic [23:0] win_bot_ff;    // bottom row, column c-1

   always_ff @(posedge clock) begin
      if (b_move) begin
         win_left_ff <= win_mid_ff;
         win_top_ff  <= top;
         win_mid_ff  <= mid;
         win_bot_ff  <= b_pix_ff;
      end
   end

   // candidate results, compacted into queue order
   result_type cand [4];
   result_type ld   [4];
   logic [2:0] pos;

   always_comb begin
      cand[0].row  = b_row_ff - 12'd1;
      cand[0].col  = b_col_ff - 11'd1;
      cand[0].pix  = b_interior_ff ?
                     sharpen(win_mid_ff, win_top_ff, win_bot_ff, win_left_ff, mid) :
                     win_mid_ff;
      cand[1].row  = b_row_ff - 12'd1;
      cand[1].col  = b_col_ff;
      cand[1].pix  = mid;
      cand[2].row  = b_row_ff;
      cand[2].col  = b_col_ff - 11'd1;
      cand[2].pix  = win_bot_ff;
      cand[3].row  = b_row_ff;
      cand[3].col  = b_col_ff;
      cand[3].pix  = b_pix_ff;
      for (int k = 0; k < 4; k++) begin
         cand[k].last = b_en_ff[k] && ((b_en_ff >> (k + 1)) == 4'd0);
      end
      for (int k = 0; k < 4; k++) begin
         ld[k] = cand[3];
      end
      pos = 3'd0;
      for (int k = 0; k < 4; k++) begin
         if (b_en_ff[k]) begin
            ld[pos[1:0]] = cand[k];
            pos = pos + 3'd1;
         end
      end
   end

   // output queue, head drives the rsp_ ports
   result_type ent_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else if (c_load) begin
         count_ff <= pos;
      end else if (take) begin
         count_ff <= count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         for (int k = 0; k < 4; k++) begin
            ent_ff[k] <= ld[k];
         end
      end else if (take) begin
         for (int k = 0; k < 3; k++) begin
            ent_ff[k] <= ent_ff[k + 1];
         end
      end
   end

   assign rsp_valid     = (count_ff != 3'd0);
   assign rsp_out_row   = ent_ff[0].row;
   assign rsp_out_col   = ent_ff[0].col;
   assign rsp_out_blue  = ent_ff[0].pix[7:0];
   assign rsp_out_green = ent_ff[0].pix[15:8];
   assign rsp_out_red   = ent_ff[0].pix[23:16];
   assign rsp_run_last  = ent_ff[0].last;

`ifndef SYNTH
   // a read and the write-back of the previous word never hit the same line entry
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (accept && b_move) |-> (raddr != b_addr_ff))
      else $error("line RAM read and write at the same entry");

   // a word enters the RAM stage only when that stage is free or draining
   a_stage_free: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!b_valid_ff || b_move))
      else $error("RAM stage overrun");

   // queue never holds more than four results
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("output queue count out of range");

   // the last word of a frame returns the counters to the origin
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && row_end && last_row) |=> (row_ff == 12'd0 && col_ff == 11'd0))
      else $error("counters did not wrap at frame end");

   // the queue is loaded only when empty or when its last result is being taken
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      c_load |-> (count_ff == 3'd0 || (count_ff == 3'd1 && take)))
      else $error("output queue loaded while holding results");
`endif

endmodule
`default_nettype wire
